### src/best_fit_segment_allocator_defines.svh
// ----------------------------------------------------------------------------
// Best-fit segment allocator: assertion macros
// Shared property forms for the checker of the allocator's ports.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BFSA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bfsa: same-cycle property failed");

// Next-cycle implication, checked outside reset.
`define BFSA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bfsa: next-cycle property failed");

`endif

### src/bfsa_pkg.sv
// ----------------------------------------------------------------------------
// Best-fit segment allocator package
// Defaults, result codes, controller states and control structs.
// ----------------------------------------------------------------------------
package bfsa_pkg;

   localparam int MEMORY_UNITS_DEF = 2048;
   localparam int MAX_SEGMENTS_DEF = 64;

   typedef enum logic [1:0] {
      ST_GRANTED = 2'd0,
      ST_NO_FIT  = 2'd1,
      ST_FULL    = 2'd2,
      ST_UNKNOWN = 2'd3
   } status_type;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_SCAN  = 8'b0000_0010,
      S_DRAIN = 8'b0000_0100,
      S_PLAN  = 8'b0000_1000,
      S_MOVE  = 8'b0001_0000,
      S_WR0   = 8'b0010_0000,
      S_WR1   = 8'b0100_0000,
      S_RESP  = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic plan;
      logic move;
      logic wr0;
      logic wr1;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic mv_done;
   } stat_type;

endpackage

### src/bfsa_ctrl.sv
// ----------------------------------------------------------------------------
// Best-fit segment allocator controller
// Sequences scan, plan, entry moves, final writes and the response.
// ----------------------------------------------------------------------------
module bfsa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output logic               rsp_strobe,
   input  bfsa_pkg::stat_type stat,
   output bfsa_pkg::cmd_type  cmd
);

   bfsa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfsa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         bfsa_pkg::S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = bfsa_pkg::S_SCAN;
            end
         end
         bfsa_pkg::S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_last) begin
               state_in = bfsa_pkg::S_DRAIN;
            end
         end
         bfsa_pkg::S_DRAIN: begin
            state_in = bfsa_pkg::S_PLAN;
         end
         bfsa_pkg::S_PLAN: begin
            cmd.plan = 1'b1;
            state_in = bfsa_pkg::S_MOVE;
         end
         bfsa_pkg::S_MOVE: begin
            cmd.move = 1'b1;
            if (stat.mv_done) begin
               state_in = bfsa_pkg::S_WR0;
            end
         end
         bfsa_pkg::S_WR0: begin
            cmd.wr0  = 1'b1;
            state_in = bfsa_pkg::S_WR1;
         end
         bfsa_pkg::S_WR1: begin
            cmd.wr1  = 1'b1;
            state_in = bfsa_pkg::S_RESP;
         end
         bfsa_pkg::S_RESP: begin
            state_in = bfsa_pkg::S_IDLE;
         end
         default: begin
            state_in = bfsa_pkg::S_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != bfsa_pkg::S_IDLE);
   assign rsp_strobe = (state_ff == bfsa_pkg::S_RESP);

endmodule

### src/bfsa_datapath.sv
// ----------------------------------------------------------------------------
// Best-fit segment allocator datapath
// Segment memory, scan compare, update planning and the entry mover.
// ----------------------------------------------------------------------------
module bfsa_datapath #(
   parameter int MEMORY_UNITS = bfsa_pkg::MEMORY_UNITS_DEF,
   parameter int MAX_SEGMENTS = bfsa_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bfsa_pkg::cmd_type                 cmd,
   output bfsa_pkg::stat_type                stat,
   input  logic                              req_mode,
   input  logic [$clog2(MEMORY_UNITS):0]     req_request_size,
   input  logic [$clog2(MEMORY_UNITS)-1:0]   req_release_address,
   output logic [1:0]                        rsp_status,
   output logic [$clog2(MEMORY_UNITS)-1:0]   rsp_granted_address
);

   localparam int AW = $clog2(MEMORY_UNITS);
   localparam int SW = AW + 1;
   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);

   typedef struct packed {
      logic [AW-1:0] start;
      logic [SW-1:0] stop;
      logic          hole;
   } seg_type;

   localparam seg_type SEG_RESET = '{start: '0, stop: SW'(MEMORY_UNITS), hole: 1'b1};

   seg_type mem_ff [MAX_SEGMENTS];
   seg_type rdata_ff;
   logic    rd_init_ff, init0_ff;

   logic          mode_ff;
   logic [SW-1:0] size_ff;
   logic [AW-1:0] addr_ff;
   logic [CW-1:0] count_ff;

   logic          scan_v_ff;
   logic [IW-1:0] ptr_ff, scan_idx_ff;
   logic          found_ff, pend_ff;
   logic [IW-1:0] best_ff;
   logic [SW-1:0] best_sz_ff;
   seg_type       cur_ff, prev_ff, next_ff, last_ff;

   logic          mv_up_ff, mv_d2_ff, mv_v_ff;
   logic [IW-1:0] mv_src_ff, mv_dst_ff;
   logic [CW-1:0] mv_left_ff;
   logic          w0_v_ff, w1_v_ff;
   logic [IW-1:0] w0_idx_ff, w1_idx_ff;
   seg_type       w0_data_ff, w1_data_ff;
   logic [1:0]    status_ff;
   logic [AW-1:0] gaddr_ff;

   seg_type       rd_data, wd;
   logic [IW-1:0] ra, wa;
   logic          we, mv_issue;
   logic [SW-1:0] sz;
   logic          fit, match, take;

   // Plan values, taken into the plan registers in the plan step.
   logic          p_up, p_d2, p_w0v, p_w1v;
   logic [IW-1:0] p_src, p_w0i, p_w1i;
   logic [CW-1:0] p_left, p_count, b1;
   seg_type       p_w0d, p_w1d;
   logic [1:0]    p_status;
   logic [AW-1:0] p_gaddr;
   logic [SW-1:0] cut;
   logic          has_next, nh, ph;

   // Entry zero holds the whole-memory hole until it is first written.
   assign rd_data  = rd_init_ff ? SEG_RESET : rdata_ff;
   assign mv_issue = cmd.move && (mv_left_ff != '0);
   assign ra       = cmd.scan ? ptr_ff : mv_src_ff;

   always_comb begin
      we = 1'b0;
      wa = mv_dst_ff;
      wd = rd_data;
      if (mv_v_ff) begin
         we = 1'b1;
      end else if (cmd.wr0 && w0_v_ff) begin
         we = 1'b1;
         wa = w0_idx_ff;
         wd = w0_data_ff;
      end else if (cmd.wr1 && w1_v_ff) begin
         we = 1'b1;
         wa = w1_idx_ff;
         wd = w1_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wa] <= wd;
      end
      rdata_ff <= mem_ff[ra];
   end

   assign sz    = rd_data.stop - {1'b0, rd_data.start};
   assign fit   = rd_data.hole && (sz >= size_ff) && (!found_ff || (sz < best_sz_ff));
   assign match = !found_ff && (rd_data.start == addr_ff);
   assign take  = scan_v_ff && (mode_ff ? match : fit);

   assign b1       = CW'(best_ff) + CW'(1);
   assign has_next = (b1 < count_ff);
   assign nh       = has_next && next_ff.hole;
   assign ph       = (best_ff != '0) && prev_ff.hole;
   assign cut      = {1'b0, cur_ff.start} + size_ff;

   always_comb begin
      p_up     = 1'b0;
      p_d2     = 1'b0;
      p_src    = best_ff + IW'(1);
      p_left   = '0;
      p_w0v    = 1'b0;
      p_w0i    = best_ff;
      p_w0d    = cur_ff;
      p_w1v    = 1'b0;
      p_w1i    = best_ff;
      p_w1d    = '{start: cur_ff.start, stop: cut, hole: 1'b0};
      p_count  = count_ff;
      p_status = bfsa_pkg::ST_GRANTED;
      p_gaddr  = '0;
      if (!mode_ff) begin
         if ((size_ff == '0) || !found_ff) begin
            p_status = bfsa_pkg::ST_NO_FIT;
         end else if (cut == cur_ff.stop) begin
            p_w0v   = 1'b1;
            p_w0d   = '{start: cur_ff.start, stop: cut, hole: 1'b0};
            p_gaddr = cur_ff.start;
         end else if (nh) begin
            // The remainder joins the hole that follows.
            p_w0v   = 1'b1;
            p_w0i   = best_ff + IW'(1);
            p_w0d   = '{start: cut[AW-1:0], stop: next_ff.stop, hole: 1'b1};
            p_w1v   = 1'b1;
            p_gaddr = cur_ff.start;
         end else if (count_ff >= CW'(MAX_SEGMENTS)) begin
            p_status = bfsa_pkg::ST_FULL;
         end else begin
            p_up    = 1'b1;
            p_src   = IW'(count_ff - CW'(1));
            p_left  = count_ff - b1;
            p_w0v   = 1'b1;
            p_w0i   = best_ff + IW'(1);
            p_w0d   = '{start: cut[AW-1:0], stop: cur_ff.stop, hole: 1'b1};
            p_w1v   = 1'b1;
            p_count = count_ff + CW'(1);
            p_gaddr = cur_ff.start;
         end
      end else begin
         if (!found_ff || cur_ff.hole) begin
            p_status = bfsa_pkg::ST_UNKNOWN;
         end else if (ph && nh) begin
            p_w0v   = 1'b1;
            p_w0i   = best_ff - IW'(1);
            p_w0d   = '{start: prev_ff.start, stop: next_ff.stop, hole: 1'b1};
            p_d2    = 1'b1;
            p_src   = best_ff + IW'(2);
            p_left  = count_ff - b1 - CW'(1);
            p_count = count_ff - CW'(2);
         end else if (ph) begin
            p_w0v   = 1'b1;
            p_w0i   = best_ff - IW'(1);
            p_w0d   = '{start: prev_ff.start, stop: cur_ff.stop, hole: 1'b1};
            p_src   = best_ff + IW'(1);
            p_left  = count_ff - b1;
            p_count = count_ff - CW'(1);
         end else if (nh) begin
            p_w0v   = 1'b1;
            p_w0d   = '{start: cur_ff.start, stop: next_ff.stop, hole: 1'b1};
            p_src   = best_ff + IW'(2);
            p_left  = count_ff - b1 - CW'(1);
            p_count = count_ff - CW'(1);
         end else begin
            p_w0v = 1'b1;
            p_w0d = '{start: cur_ff.start, stop: cur_ff.stop, hole: 1'b1};
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         init0_ff   <= 1'b1;
         rd_init_ff <= 1'b0;
         count_ff   <= CW'(1);
         scan_v_ff  <= 1'b0;
         found_ff   <= 1'b0;
         pend_ff    <= 1'b0;
         mv_v_ff    <= 1'b0;
         mv_left_ff <= '0;
         w0_v_ff    <= 1'b0;
         w1_v_ff    <= 1'b0;
      end else begin
         rd_init_ff <= (ra == '0) && init0_ff;
         if (we && (wa == '0)) begin
            init0_ff <= 1'b0;
         end
         scan_v_ff <= cmd.scan;
         mv_v_ff   <= mv_issue;
         if (cmd.load) begin
            found_ff <= 1'b0;
            pend_ff  <= 1'b0;
         end else if (scan_v_ff) begin
            pend_ff <= take;
            if (take) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.plan) begin
            mv_left_ff <= p_left;
            w0_v_ff    <= p_w0v;
            w1_v_ff    <= p_w1v;
            count_ff   <= p_count;
         end else if (mv_issue) begin
            mv_left_ff <= mv_left_ff - CW'(1);
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         size_ff <= req_request_size;
         addr_ff <= req_release_address;
         ptr_ff  <= '0;
      end else if (cmd.scan) begin
         ptr_ff <= ptr_ff + IW'(1);
      end
      scan_idx_ff <= ptr_ff;
      if (scan_v_ff) begin
         last_ff <= rd_data;
         if (pend_ff) begin
            next_ff <= rd_data;
         end
         if (take) begin
            best_ff    <= scan_idx_ff;
            best_sz_ff <= sz;
            cur_ff     <= rd_data;
            prev_ff    <= last_ff;
         end
      end
      if (cmd.plan) begin
         mv_up_ff   <= p_up;
         mv_d2_ff   <= p_d2;
         mv_src_ff  <= p_src;
         w0_idx_ff  <= p_w0i;
         w0_data_ff <= p_w0d;
         w1_idx_ff  <= p_w1i;
         w1_data_ff <= p_w1d;
         status_ff  <= p_status;
         gaddr_ff   <= p_gaddr;
      end else if (mv_issue) begin
         mv_src_ff <= mv_up_ff ? (mv_src_ff - IW'(1)) : (mv_src_ff + IW'(1));
         mv_dst_ff <= mv_up_ff ? (mv_src_ff + IW'(1))
                    : (mv_src_ff - (mv_d2_ff ? IW'(2) : IW'(1)));
      end
   end

   assign stat.scan_last   = (CW'(ptr_ff) == (count_ff - CW'(1)));
   assign stat.mv_done     = (mv_left_ff == '0) && !mv_v_ff;
   assign rsp_status          = status_ff;
   assign rsp_granted_address = gaddr_ff;

endmodule

### src/best_fit_segment_allocator.sv
// The scan reads the N live segments, one table read a cycle; then M entries shift (0..N-1).
// One word at a time: the next word is taken in the cycle after the strobe at the earliest.
// Each result is shown for one cycle on rsp_strobe; the receiver cannot stall.
// Synchronous active-high reset: one whole-memory hole, busy low, no clearing pass.
// ----------------------------------------------------------------------------
// Best-fit segment allocator
// Allocates and frees segments of a fixed memory with hole coalescing.
// ----------------------------------------------------------------------------
module best_fit_segment_allocator #(
   parameter int MEMORY_UNITS = bfsa_pkg::MEMORY_UNITS_DEF,
   parameter int MAX_SEGMENTS = bfsa_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_mode,
   input  logic [$clog2(MEMORY_UNITS):0]   req_request_size,
   input  logic [$clog2(MEMORY_UNITS)-1:0] req_release_address,
   output logic                            rsp_strobe,
   output logic [1:0]                      rsp_status,
   output logic [$clog2(MEMORY_UNITS)-1:0] rsp_granted_address
);

   bfsa_pkg::cmd_type  cmd;
   bfsa_pkg::stat_type stat;

   bfsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .stat       (stat),
      .cmd        (cmd)
   );

   bfsa_datapath #(
      .MEMORY_UNITS (MEMORY_UNITS),
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_mode            (req_mode),
      .req_request_size    (req_request_size),
      .req_release_address (req_release_address),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address)
   );

endmodule

### src/bfsa_checker.sv
// ----------------------------------------------------------------------------
// Best-fit segment allocator port checker
// Watches the command and response ports over time.
// ----------------------------------------------------------------------------
`include "best_fit_segment_allocator_defines.svh"

module bfsa_checker #(
   parameter int MEMORY_UNITS = bfsa_pkg::MEMORY_UNITS_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_strobe,
   input logic [1:0]                      rsp_status,
   input logic [$clog2(MEMORY_UNITS)-1:0] rsp_granted_address
);

   // An accepted word keeps the block busy in the following cycle.
   `BFSA_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy)
   // A response comes only while busy, and the block is free right after it.
   `BFSA_ASSERT_IMP(a_resp_busy, clock, reset, rsp_strobe, busy)
   `BFSA_ASSERT_NXT(a_resp_idle, clock, reset, rsp_strobe, !busy && !rsp_strobe)
   // Only a granted allocation carries a non-zero address.
   `BFSA_ASSERT_IMP(a_addr_zero, clock, reset,
      rsp_strobe && (rsp_status != bfsa_pkg::ST_GRANTED), rsp_granted_address == '0)

endmodule

bind best_fit_segment_allocator bfsa_checker #(.MEMORY_UNITS(MEMORY_UNITS)) u_checker (.*);
